[rtl/core/adjacency_handshake_fsm_core_assert.svh]
// Assertion macros for the adjacency handshake core.
// Used by the top level; expects clk and rst in scope.
`ifndef ADJACENCY_HANDSHAKE_FSM_CORE_ASSERT_SVH
`define ADJACENCY_HANDSHAKE_FSM_CORE_ASSERT_SVH

// ante |-> cons in the same cycle
`define AHF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// ante |=> cons in the next cycle
`define AHF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/ahf_pkg.sv]
// Package of the adjacency handshake core: codes, state type, payload structs.
// No dependencies.
package ahf_pkg;

  localparam int MISS_LIMIT = 3;

  localparam logic [1:0] OP_MSG   = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  localparam logic [1:0] CODE_SYN    = 2'd0;
  localparam logic [1:0] CODE_SYNACK = 2'd1;
  localparam logic [1:0] CODE_ACK    = 2'd2;
  localparam logic [1:0] CODE_RSTACK = 2'd3;

  localparam logic [1:0] LINK_SYNSENT = 2'd0;
  localparam logic [1:0] LINK_SYNRCVD = 2'd1;
  localparam logic [1:0] LINK_ESTAB   = 2'd2;
  localparam logic [1:0] LINK_DEAD    = 2'd3;

  localparam logic [1:0] CFG_MY_MAC     = 2'd0;
  localparam logic [1:0] CFG_MY_PORT    = 2'd1;
  localparam logic [1:0] CFG_IS_NAS     = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT_MS = 2'd3;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  typedef enum logic [3:0] {
    ST_SYNSENT = 4'b0001,
    ST_SYNRCVD = 4'b0010,
    ST_ESTAB   = 4'b0100,
    ST_DEAD    = 4'b1000
  } adj_state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  adj_code;
    logic [47:0] rx_sender_mac;
    logic [23:0] rx_sender_instance;
    logic [31:0] rx_sender_port;
    logic [47:0] rx_receiver_mac;
    logic [23:0] rx_receiver_instance;
    logic [31:0] rx_receiver_port;
  } in_item_t;

  typedef struct packed {
    logic        send_valid;
    logic [1:0]  tx_code;
    logic [47:0] tx_sender_mac;
    logic [23:0] tx_sender_instance;
    logic [31:0] tx_sender_port;
    logic [47:0] tx_receiver_mac;
    logic [23:0] tx_receiver_instance;
    logic [31:0] tx_receiver_port;
    logic        tx_nas_flag;
    logic [1:0]  link_state;
    logic        became_established;
  } out_item_t;

  typedef struct packed {
    logic [47:0] my_mac;
    logic [31:0] my_port;
    logic        is_nas;
    logic [15:0] timeout_ms;
  } cfg_t;

  typedef struct packed {
    adj_state_t st;
    logic       timer_armed;
  } eng_status_t;

  function automatic logic [1:0] link_code(adj_state_t s);
    logic [1:0] c;
    case (s)
      ST_SYNSENT: c = LINK_SYNSENT;
      ST_SYNRCVD: c = LINK_SYNRCVD;
      ST_ESTAB:   c = LINK_ESTAB;
      ST_DEAD:    c = LINK_DEAD;
      default:    c = LINK_SYNSENT;
    endcase
    return c;
  endfunction

endpackage

[rtl/core/ahf_cfg_regs.sv]
// Configuration registers of the adjacency handshake core.
// Depends on ahf_pkg.
module ahf_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [47:0]   cfg_data,
  output ahf_pkg::cfg_t cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.my_mac     <= '0;
      cfg.my_port    <= '0;
      cfg.is_nas     <= 1'b0;
      cfg.timeout_ms <= ahf_pkg::TIMEOUT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        ahf_pkg::CFG_MY_MAC:     cfg.my_mac     <= cfg_data;
        ahf_pkg::CFG_MY_PORT:    cfg.my_port    <= cfg_data[31:0];
        ahf_pkg::CFG_IS_NAS:     cfg.is_nas     <= cfg_data[0];
        ahf_pkg::CFG_TIMEOUT_MS: cfg.timeout_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/ahf_in_stage.sv]
// Input register of the adjacency handshake core.
// Depends on ahf_pkg.
module ahf_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  ahf_pkg::in_item_t item,
  input  logic              advance,
  output logic              full,
  output ahf_pkg::in_item_t held
);

  assign item_ready = !full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (item_ready) begin
      full <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held <= item;
    end
  end

endmodule

[rtl/core/ahf_engine.sv]
// Adjacency state, timers and response logic; one item per cycle in which fire is high.
// Depends on ahf_pkg.
module ahf_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  ahf_pkg::in_item_t    item,
  input  ahf_pkg::cfg_t        cfg,
  output ahf_pkg::out_item_t   result,
  output ahf_pkg::eng_status_t status
);

  ahf_pkg::adj_state_t st, st_next;
  logic [23:0] own_instance, own_instance_next;
  logic [47:0] peer_mac, peer_mac_next;
  logic [23:0] peer_instance, peer_instance_next;
  logic [31:0] peer_port, peer_port_next;
  logic [2:0]  missed, missed_next;
  logic        timer_armed, timer_armed_next;
  logic [15:0] timer_remaining, timer_remaining_next;
  logic [15:0] ms_since_ack, ms_since_ack_next;

  logic        cond_a, cond_b, cond_c;
  logic [23:0] inst_inc;
  logic [15:0] ms_base;
  logic        own_req, own_send, mirror, ka_rst;
  logic [1:0]  own_code;

  assign cond_a = peer_instance == item.rx_sender_instance;
  assign cond_b = cond_a && peer_mac == item.rx_sender_mac && peer_port == item.rx_sender_port;
  assign cond_c = cfg.my_mac == item.rx_receiver_mac &&
                  own_instance == item.rx_receiver_instance &&
                  cfg.my_port == item.rx_receiver_port;
  assign inst_inc = own_instance + 24'd1;

  always_comb begin
    st_next              = st;
    own_instance_next    = own_instance;
    peer_mac_next        = peer_mac;
    peer_instance_next   = peer_instance;
    peer_port_next       = peer_port;
    missed_next          = missed;
    timer_armed_next     = timer_armed;
    timer_remaining_next = timer_remaining;
    ms_since_ack_next    = ms_since_ack;
    ms_base              = ms_since_ack;
    own_req              = 1'b0;
    own_code             = ahf_pkg::CODE_SYN;
    mirror               = 1'b0;
    ka_rst               = 1'b0;

    case (item.operation)
      ahf_pkg::OP_MSG: begin
        if (item.adj_code == ahf_pkg::CODE_RSTACK) begin
          if (cond_a && cond_c && st != ahf_pkg::ST_SYNSENT) begin
            own_instance_next  = (inst_inc == '0) ? 24'd1 : inst_inc;
            peer_mac_next      = '0;
            peer_instance_next = '0;
            peer_port_next     = '0;
            st_next            = ahf_pkg::ST_SYNSENT;
            own_req            = 1'b1;
            own_code           = ahf_pkg::CODE_SYN;
          end
        end else if (st == ahf_pkg::ST_ESTAB) begin
          if (item.adj_code == ahf_pkg::CODE_ACK && !(cond_b && cond_c)) begin
            mirror = 1'b1;
          end else begin
            missed_next = '0;
            own_req     = 1'b1;
            own_code    = ahf_pkg::CODE_ACK;
          end
        end else begin
          case (item.adj_code)
            ahf_pkg::CODE_SYN: begin
              peer_mac_next      = item.rx_sender_mac;
              peer_instance_next = item.rx_sender_instance;
              peer_port_next     = item.rx_sender_port;
              own_req            = 1'b1;
              own_code           = ahf_pkg::CODE_SYNACK;
              st_next            = ahf_pkg::ST_SYNRCVD;
            end
            ahf_pkg::CODE_SYNACK: begin
              if (cond_c) begin
                peer_mac_next      = item.rx_sender_mac;
                peer_instance_next = item.rx_sender_instance;
                peer_port_next     = item.rx_sender_port;
                own_req            = 1'b1;
                own_code           = ahf_pkg::CODE_ACK;
                st_next            = ahf_pkg::ST_ESTAB;
              end else begin
                mirror = 1'b1;
              end
            end
            default: begin
              if (st != ahf_pkg::ST_SYNSENT && cond_b && cond_c) begin
                own_req  = 1'b1;
                own_code = ahf_pkg::CODE_ACK;
                st_next  = ahf_pkg::ST_ESTAB;
              end else begin
                mirror = 1'b1;
              end
            end
          endcase
        end
      end
      ahf_pkg::OP_TICK: begin
        ms_base           = (ms_since_ack != '1) ? ms_since_ack + 16'd1 : ms_since_ack;
        ms_since_ack_next = ms_base;
        if (timer_armed) begin
          if (timer_remaining <= 16'd1) begin
            timer_remaining_next = '0;
            timer_armed_next     = 1'b0;
            case (st)
              ahf_pkg::ST_SYNSENT: begin
                own_req  = 1'b1;
                own_code = ahf_pkg::CODE_SYN;
              end
              ahf_pkg::ST_SYNRCVD: begin
                own_req  = 1'b1;
                own_code = ahf_pkg::CODE_SYNACK;
              end
              ahf_pkg::ST_ESTAB: begin
                missed_next = (missed != '1) ? missed + 3'd1 : missed;
                if (missed < 3'(ahf_pkg::MISS_LIMIT)) begin
                  own_req  = 1'b1;
                  own_code = ahf_pkg::CODE_ACK;
                end else begin
                  ka_rst  = 1'b1;
                  st_next = ahf_pkg::ST_DEAD;
                end
              end
              default: ;
            endcase
          end else begin
            timer_remaining_next = timer_remaining - 16'd1;
          end
        end
      end
      ahf_pkg::OP_START: begin
        if (!cfg.is_nas) begin
          st_next  = ahf_pkg::ST_SYNSENT;
          own_req  = 1'b1;
          own_code = ahf_pkg::CODE_SYN;
        end
      end
      default: ;
    endcase

    own_send = own_req &&
               !(own_code == ahf_pkg::CODE_ACK && ms_base < cfg.timeout_ms);
    if (own_send) begin
      timer_armed_next     = 1'b1;
      timer_remaining_next = cfg.timeout_ms;
      if (own_code == ahf_pkg::CODE_ACK) begin
        ms_since_ack_next = '0;
      end
    end
  end

  always_comb begin
    result = '0;
    if (own_send) begin
      result.send_valid           = 1'b1;
      result.tx_code              = own_code;
      result.tx_sender_mac        = cfg.my_mac;
      result.tx_sender_instance   = own_instance_next;
      result.tx_sender_port       = cfg.my_port;
      result.tx_receiver_mac      = peer_mac_next;
      result.tx_receiver_instance = peer_instance_next;
      result.tx_receiver_port     = peer_port_next;
      result.tx_nas_flag          = (own_code == ahf_pkg::CODE_SYN) ? cfg.is_nas : 1'b0;
    end else if (mirror) begin
      result.send_valid           = 1'b1;
      result.tx_code              = ahf_pkg::CODE_RSTACK;
      result.tx_sender_mac        = item.rx_receiver_mac;
      result.tx_sender_instance   = item.rx_receiver_instance;
      result.tx_sender_port       = item.rx_receiver_port;
      result.tx_receiver_mac      = item.rx_sender_mac;
      result.tx_receiver_instance = item.rx_sender_instance;
      result.tx_receiver_port     = item.rx_sender_port;
      result.tx_nas_flag          = cfg.is_nas;
    end else if (ka_rst) begin
      result.send_valid           = 1'b1;
      result.tx_code              = ahf_pkg::CODE_RSTACK;
      result.tx_sender_mac        = cfg.my_mac;
      result.tx_sender_instance   = own_instance;
      result.tx_sender_port       = cfg.my_port;
      result.tx_receiver_mac      = peer_mac;
      result.tx_receiver_instance = peer_instance;
      result.tx_receiver_port     = peer_port;
      result.tx_nas_flag          = cfg.is_nas;
    end
    result.link_state         = ahf_pkg::link_code(st_next);
    result.became_established = st != ahf_pkg::ST_ESTAB && st_next == ahf_pkg::ST_ESTAB;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st              <= ahf_pkg::ST_SYNSENT;
      own_instance    <= 24'd1;
      peer_mac        <= '0;
      peer_instance   <= '0;
      peer_port       <= '0;
      missed          <= '0;
      timer_armed     <= 1'b0;
      timer_remaining <= '0;
      ms_since_ack    <= '0;
    end else if (fire) begin
      st              <= st_next;
      own_instance    <= own_instance_next;
      peer_mac        <= peer_mac_next;
      peer_instance   <= peer_instance_next;
      peer_port       <= peer_port_next;
      missed          <= missed_next;
      timer_armed     <= timer_armed_next;
      timer_remaining <= timer_remaining_next;
      ms_since_ack    <= ms_since_ack_next;
    end
  end

  assign status.st          = st;
  assign status.timer_armed = timer_armed;

endmodule

[rtl/core/ahf_out_stage.sv]
// Result register of the adjacency handshake core.
// Depends on ahf_pkg.
module ahf_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  ahf_pkg::out_item_t data,
  output logic               can_load,
  output logic               result_valid,
  input  logic               result_ready,
  output ahf_pkg::out_item_t result
);

  assign can_load = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= data;
    end
  end

endmodule

[rtl/core/adjacency_handshake_fsm_core.sv]
// Top level of the adjacency handshake core: input register, engine, result register.
// Depends on ahf_pkg, ahf_cfg_regs, ahf_in_stage, ahf_engine, ahf_out_stage.
//
// Every accepted item (received header, millisecond tick or start) yields exactly one
// result: the item waits in the input register, its result in the result register.
// One item is taken per cycle while the result side is ready: the state update and
// response are formed combinationally between them, so items may arrive back to back.
// Configuration writes are taken every cycle and should only be issued while idle.
`include "adjacency_handshake_fsm_core_assert.svh"

module adjacency_handshake_fsm_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  ahf_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_ready,
  output ahf_pkg::out_item_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [47:0]        cfg_data
);

  ahf_pkg::cfg_t        cfg;
  ahf_pkg::in_item_t    held;
  ahf_pkg::out_item_t   eng_result;
  ahf_pkg::eng_status_t status;
  logic                 in_full;
  logic                 can_load;
  logic                 advance;

  assign advance = in_full && can_load;

  ahf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ahf_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .advance    (advance),
    .full       (in_full),
    .held       (held)
  );

  ahf_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (held),
    .cfg    (cfg),
    .result (eng_result),
    .status (status)
  );

  ahf_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (advance),
    .data         (eng_result),
    .can_load     (can_load),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  `AHF_ASSERT_NEXT(a_advance_gives_result, advance, result_valid, "transfer lost after advance")
  `AHF_ASSERT_NEXT(a_send_arms_timer, advance && eng_result.send_valid && eng_result.tx_code != ahf_pkg::CODE_RSTACK, status.timer_armed, "sent message did not arm timer")
  `AHF_ASSERT_NEXT(a_estab_entered, advance && eng_result.became_established, status.st == ahf_pkg::ST_ESTAB, "established flag without ESTAB")
  `AHF_ASSERT_SAME(a_rstack_no_establish, advance && eng_result.send_valid && eng_result.tx_code == ahf_pkg::CODE_RSTACK, !eng_result.became_established, "RSTACK with establish")

endmodule
